// ----- hw/rtl/utf8_decoder_with_replacement_defines.svh -----
// Assertion helpers shared by the decoder RTL.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/utf8d_pkg.sv -----
package utf8d_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned PARTIAL_W = 15;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_CP_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_LEN4    = 21'h010000;
    localparam logic [CP_W-1:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] ASCII_END = 8'h80;

    // Open sequence: collected bits, bytes held (0 = none), total length.
    typedef struct packed {
        logic [PARTIAL_W-1:0] partial;
        logic [1:0]           held;
        logic [2:0]           seq_len;
    } t_seq_state;

    // What one input word produces: a run of replacement words, then
    // an optional closing word.
    typedef struct packed {
        logic [2:0]      err_cnt;
        logic            tail_valid;
        logic [CP_W-1:0] tail_cp;
        logic            tail_err;
    } t_step_result;

endpackage

// ----- hw/rtl/utf8_decoder_with_replacement.sv -----
// Channel  Direction  Handshake                 Payload
// in       into       i_in_valid / o_in_ready   i_in_byte[7:0]
// out      out of     o_out_valid / i_out_ready o_code_point[20:0], o_was_error,
//                                               o_last_of_run
//
// A byte is decoded in the cycle it is accepted and its results land in an
// output buffer; the output side then drains one word per cycle while i_out_ready
// is high. A byte that yields zero or one word sustains one byte per cycle while
// the receiver keeps up. A byte that yields n words (up to four, error bursts)
// holds the input until n - 1 have left through the buffer's single output port.
// Reset is synchronous and active low; it closes any open sequence and
// empties the result buffer. Output stalls hold the word shown unchanged.
`include "utf8_decoder_with_replacement_defines.svh"

module utf8_decoder_with_replacement
    import utf8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_was_error,
    output logic            o_last_of_run
);

    // Decoder state for the open multi-byte sequence.
    t_seq_state r_state, n_state;

    // Result buffer: a count of pending replacement words, followed by an
    // optional closing word (a decoded value, ASCII, or a bad-lead error).
    logic [2:0]      r_err_cnt, n_err_cnt;
    logic            r_tail_valid, n_tail_valid;
    logic [CP_W-1:0] r_tail_cp;
    logic            r_tail_err;

    t_seq_state   step_next;
    t_step_result step_res;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pending;

    utf8d_step u_step (
        .i_byte       (i_in_byte),
        .i_state      (r_state),
        .o_next_state (step_next),
        .o_result     (step_res)
    );

    assign pending = r_err_cnt + {2'd0, r_tail_valid};

    // A new byte can enter when the buffer is empty or its last word
    // leaves in this very cycle.
    assign o_in_ready  = (pending == 3'd0) || ((pending == 3'd1) && i_out_ready);
    assign o_out_valid = (pending != 3'd0);

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Replacement words go first; the closing word comes last.
    assign o_code_point  = (r_err_cnt != 3'd0) ? REPLACEMENT_CP : r_tail_cp;
    assign o_was_error   = (r_err_cnt != 3'd0) ? 1'b1 : r_tail_err;
    assign o_last_of_run = (r_err_cnt == 3'd0) || ((r_err_cnt == 3'd1) && !r_tail_valid);

    always_comb begin
        n_state      = r_state;
        n_err_cnt    = r_err_cnt;
        n_tail_valid = r_tail_valid;
        if (in_acc) begin
            n_state      = step_next;
            n_err_cnt    = step_res.err_cnt;
            n_tail_valid = step_res.tail_valid;
        end else if (out_acc) begin
            if (r_err_cnt != 3'd0) begin
                n_err_cnt = r_err_cnt - 3'd1;
            end else begin
                n_tail_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_err_cnt    <= 3'd0;
            r_tail_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_err_cnt    <= n_err_cnt;
            r_tail_valid <= n_tail_valid;
        end
    end

    // The closing word's payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tail_cp  <= step_res.tail_cp;
            r_tail_err <= step_res.tail_err;
        end
    end

    `UTF8D_ASSERT_SAME(a_ready_only_on_drain, o_in_ready && o_out_valid,
        (pending == 3'd1) && i_out_ready, "input taken while results remain")
    `UTF8D_ASSERT_NEXT(a_empty_after_last, out_acc && o_last_of_run && !in_acc,
        !o_out_valid, "buffer not empty after last word of a run")
    `UTF8D_ASSERT_SAME(a_tail_err_is_repl, r_tail_valid && r_tail_err,
        r_tail_cp == REPLACEMENT_CP, "error word is not the replacement character")
    `UTF8D_ASSERT_SAME(a_open_seq_sane, r_state.held != 2'd0,
        (r_state.seq_len >= 3'd2) && ({1'b0, r_state.held} < r_state.seq_len),
        "open sequence holds an impossible byte count")
    `UTF8D_ASSERT_SAME(a_burst_bound, 1'b1, pending <= 3'd4,
        "more than four words pending")

endmodule

// ----- hw/rtl/utf8d_step.sv -----
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [7:0]   i_byte,
    input  t_seq_state   i_state,
    output t_seq_state   o_next_state,
    output t_step_result o_result
);

    logic            lead;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] min_cp;
    logic [2:0]      held_inc;
    logic            bad_value;

    assign cp       = {i_state.partial, i_byte[5:0]};
    assign held_inc = {1'b0, i_state.held} + 3'd1;

    always_comb begin
        case (i_state.seq_len)
            3'd2:    min_cp = MIN_CP_LEN2;
            3'd3:    min_cp = MIN_CP_LEN3;
            default: min_cp = MIN_CP_LEN4;
        endcase
    end

    assign bad_value = (cp < min_cp) || ((cp >= SURROGATE_LO) && (cp <= SURROGATE_HI))
                     || (cp > MAX_CP);

    always_comb begin
        o_next_state = i_state;
        o_result     = '0;
        lead         = 1'b1;

        if (i_state.held != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                lead = 1'b0;
                if (held_inc >= i_state.seq_len) begin
                    // Sequence complete: either the value or one error per byte.
                    if (bad_value) begin
                        o_result.err_cnt = i_state.seq_len;
                    end else begin
                        o_result.tail_valid = 1'b1;
                        o_result.tail_cp    = cp;
                    end
                    o_next_state = '0;
                end else begin
                    o_next_state.partial = cp[PARTIAL_W-1:0];
                    o_next_state.held    = held_inc[1:0];
                end
            end else begin
                // Missing continuation: flush what is held, then reparse.
                o_result.err_cnt = {1'b0, i_state.held};
                o_next_state     = '0;
            end
        end

        if (lead) begin
            if (i_byte < ASCII_END) begin
                o_result.tail_valid = 1'b1;
                o_result.tail_cp    = {13'd0, i_byte};
            end else if ((i_byte >= LEAD2_LO) && (i_byte <= LEAD2_HI)) begin
                o_next_state.partial = {10'd0, i_byte[4:0]};
                o_next_state.held    = 2'd1;
                o_next_state.seq_len = 3'd2;
            end else if ((i_byte >= LEAD3_LO) && (i_byte <= LEAD3_HI)) begin
                o_next_state.partial = {11'd0, i_byte[3:0]};
                o_next_state.held    = 2'd1;
                o_next_state.seq_len = 3'd3;
            end else if ((i_byte >= LEAD4_LO) && (i_byte <= LEAD4_HI)) begin
                o_next_state.partial = {12'd0, i_byte[2:0]};
                o_next_state.held    = 2'd1;
                o_next_state.seq_len = 3'd4;
            end else begin
                o_result.tail_valid = 1'b1;
                o_result.tail_cp    = REPLACEMENT_CP;
                o_result.tail_err   = 1'b1;
            end
        end
    end

endmodule

// ----- tb/tb_utf8_decoder_with_replacement.sv -----
// Self-checking bench for the UTF-8 decoder with replacement.
//
// Stimulus bytes go in through the input channel; a monitor on the rising
// clock edge feeds every accepted byte into a decoder model of its own and
// queues the code point words that the byte must produce. Every word taken
// from the output channel is compared, field by field, against the oldest
// queued word. Inputs are driven on the falling edge, so nothing sampled on
// the rising edge depends on the order of events within a time step.
module tb_utf8_decoder_with_replacement;
    import utf8d_pkg::*;

    // Cycles without any handshake before the run is declared hung. The
    // longest legal quiet stretch is the forced output hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;

    // One expected output word.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            was_error;
        logic            last_of_run;
    } t_cp_word;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [7:0]      i_in_byte;
    logic            o_out_valid;
    logic            i_out_ready;
    logic [CP_W-1:0] o_code_point;
    logic            o_was_error;
    logic            o_last_of_run;

    utf8_decoder_with_replacement dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_point  (o_code_point),
        .o_was_error   (o_was_error),
        .o_last_of_run (o_last_of_run)
    );

    // Words still owed by the decoder, oldest first.
    t_cp_word expected_words[$];

    // Model copy of the open sequence.
    logic [CP_W-1:0] seq_partial;
    int              seq_held;
    int              seq_len;

    int fail_count    = 0;
    int bytes_offered = 0;
    int stuck_cycles  = 0;

    // Idle rates in percent for the sender and the receiver. They are only
    // changed on a rising edge, so the receiver, which reads its rate on
    // the falling edge, never races with the change.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Set once by the stimulus to make the receiver hold off for a long
    // stretch; the receiver clears it when it starts counting.
    bit hold_req  = 1'b0;
    int hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random idling, or a long forced stall on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left   = hold_left - 1;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void push_word(input logic [CP_W-1:0] cp, input logic err);
        t_cp_word w;
        w.code_point  = cp;
        w.was_error   = err;
        w.last_of_run = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void clear_sequence();
        seq_partial = '0;
        seq_held    = 0;
        seq_len     = 0;
    endfunction

    // Decoder model: one accepted byte in, zero to four expected words out.
    function automatic void decode_byte(input logic [7:0] b);
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] minimum;
        int              held;
        int              first;
        bit              lead;
        first = expected_words.size();
        lead  = 1'b1;
        if (seq_held != 0) begin
            if (b[7:6] == 2'b10) begin
                // A continuation extends the open sequence.
                held = seq_held + 1;
                cp   = {seq_partial[CP_W-7:0], b[5:0]};
                lead = 1'b0;
                if (held >= seq_len) begin
                    minimum = (seq_len == 2) ? MIN_CP_LEN2 :
                              (seq_len == 3) ? MIN_CP_LEN3 : MIN_CP_LEN4;
                    // Overlong, surrogate or out-of-range values replace
                    // every byte of the sequence.
                    if (cp < minimum || (cp >= SURROGATE_LO && cp <= SURROGATE_HI) ||
                        cp > MAX_CP) begin
                        repeat (seq_len) push_word(REPLACEMENT_CP, 1'b1);
                    end else begin
                        push_word(cp, 1'b0);
                    end
                    clear_sequence();
                end else begin
                    seq_partial = cp;
                    seq_held    = held;
                end
            end else begin
                // Missing continuation: flush the held bytes as errors and
                // treat this byte as a fresh lead below.
                repeat (seq_held) push_word(REPLACEMENT_CP, 1'b1);
                clear_sequence();
            end
        end
        if (lead) begin
            if (b < ASCII_END) begin
                push_word({{(CP_W-8){1'b0}}, b}, 1'b0);
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                seq_partial = {{(CP_W-5){1'b0}}, b[4:0]};
                seq_held    = 1;
                seq_len     = 2;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                seq_partial = {{(CP_W-4){1'b0}}, b[3:0]};
                seq_held    = 1;
                seq_len     = 3;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                seq_partial = {{(CP_W-3){1'b0}}, b[2:0]};
                seq_held    = 1;
                seq_len     = 4;
            end else begin
                push_word(REPLACEMENT_CP, 1'b1);
            end
        end
        if (expected_words.size() > first) begin
            expected_words[expected_words.size()-1].last_of_run = 1'b1;
        end
    endfunction

    // Monitor: the byte accepted at this edge is modeled first, then the
    // output word accepted at this edge is checked against the queue.
    always @(posedge i_clk) begin
        t_cp_word w;
        if (!i_rst_n) begin
            clear_sequence();
            expected_words.delete();
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_in_byte);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: code_point %h was_error %b last_of_run %b",
                           o_code_point, o_was_error, o_last_of_run);
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    if (o_code_point !== w.code_point) begin
                        $error("code_point: expected %h, got %h", w.code_point, o_code_point);
                        fail_count++;
                    end
                    if (o_was_error !== w.was_error) begin
                        $error("was_error: expected %b, got %b", w.was_error, o_was_error);
                        fail_count++;
                    end
                    if (o_last_of_run !== w.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               w.last_of_run, o_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offers one byte and returns on the falling edge after it was taken.
    // Valid stays high afterwards so that back-to-back bytes need no
    // second assignment in one step; drain_results lowers it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_offered++;
        @(negedge i_clk);
    endtask

    // Sender pause: wait until every owed word has come out.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        @(posedge i_clk);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        @(negedge i_clk);
    endtask

    // A random scalar value from the given length class up to four bytes,
    // with the class boundaries picked now and then.
    function automatic logic [CP_W-1:0] random_scalar(input int lowest_class);
        int              cls;
        bit              edge_pick;
        logic [CP_W-1:0] v;
        cls       = $urandom_range(3, lowest_class);
        edge_pick = ($urandom_range(4) == 0);
        case (cls)
            0: v = edge_pick ? ($urandom_range(1) ? 21'h00007F : 21'h000000)
                             : CP_W'($urandom_range(127));
            1: v = edge_pick ? ($urandom_range(1) ? 21'h0007FF : 21'h000080)
                             : CP_W'($urandom_range(16'h07FF, 16'h0080));
            2: begin
                if (edge_pick) begin
                    case ($urandom_range(4))
                        0:       v = 21'h000800;
                        1:       v = 21'h00D7FF;
                        2:       v = 21'h00E000;
                        3:       v = REPLACEMENT_CP;
                        default: v = 21'h00FFFF;
                    endcase
                end else begin
                    v = CP_W'($urandom_range(16'hFFFF, 16'h0800));
                    // Step over the surrogate range.
                    if (v >= SURROGATE_LO && v <= SURROGATE_HI) v = v + 21'h000800;
                end
            end
            default: v = edge_pick ? ($urandom_range(1) ? MAX_CP : MIN_CP_LEN4)
                                   : CP_W'($urandom_range(21'h10FFFF, 21'h010000));
        endcase
        return v;
    endfunction

    // Sends the UTF-8 encoding of cp, leaving off the last drop bytes so
    // that a sequence can be cut short; at least the lead goes out.
    task automatic send_encoded(input logic [CP_W-1:0] cp, input int drop);
        logic [7:0] enc [0:3];
        int         len;
        if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            len    = 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            len    = 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            len    = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            len    = 4;
        end
        if (drop > len - 1) drop = len - 1;
        for (int i = 0; i < len - drop; i++) send_byte(enc[i]);
    endtask

    function automatic logic [7:0] random_continuation();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // Well-formed structure that decodes to a forbidden value:
    // 0 overlong three-byte, 1 overlong four-byte, 2 surrogate, 3 above range.
    task automatic send_bad_value(input int kind);
        case (kind)
            0: begin
                send_byte(LEAD3_LO);
                send_byte(8'($urandom_range(8'h9F, 8'h80)));
            end
            1: begin
                send_byte(LEAD4_LO);
                send_byte(8'($urandom_range(8'h8F, 8'h80)));
                send_byte(random_continuation());
            end
            2: begin
                send_byte(8'hED);
                send_byte(8'($urandom_range(8'hBF, 8'hA0)));
            end
            default: begin
                send_byte(LEAD4_HI);
                send_byte(8'($urandom_range(8'hBF, 8'h90)));
                send_byte(random_continuation());
            end
        endcase
        send_byte(random_continuation());
    endtask

    // Mostly well-formed text, with cut-off sequences, forbidden values and
    // raw noise mixed in.
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)      send_encoded(random_scalar(0), 0);
        else if (pick < 70) send_encoded(random_scalar(1), $urandom_range(3, 1));
        else if (pick < 85) send_bad_value($urandom_range(3));
        else                send_byte(8'($urandom_range(255)));
    endtask

    // Zero byte, top ASCII byte, and stray bytes that cannot lead.
    task automatic test_single_bytes();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        drain_results();
    endtask

    // Smallest two-byte value, and an encoded replacement character, which
    // must not be flagged as an error.
    task automatic test_well_formed();
        send_encoded(MIN_CP_LEN2, 0);
        send_encoded(REPLACEMENT_CP, 0);
        drain_results();
    endtask

    // Overlong, surrogate and beyond-range values: one replacement per byte.
    task automatic test_forbidden_values();
        send_byte(LEAD3_LO);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(8'h80);
        send_byte(LEAD4_HI);
        send_byte(8'h90);
        send_byte(8'h80);
        send_byte(8'h80);
        drain_results();
    endtask

    // A four-byte sequence broken by an ASCII byte after two bytes: two
    // replacements, then the ASCII byte itself.
    task automatic test_missing_continuation();
        send_byte(LEAD4_LO);
        send_byte(8'h90);
        send_byte(8'h41);
        drain_results();
    endtask

    // The receiver stalls for a long stretch while four-word error bursts
    // keep coming, so the result buffer fills and the input backs up.
    task automatic test_output_stall();
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (12) send_bad_value(3);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count);
        int start;
        start = bytes_offered;
        while (bytes_offered - start < count) send_random_item();
        drain_results();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_out_ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_idle(37, 78);
        test_single_bytes();
        test_well_formed();
        test_forbidden_values();
        test_missing_continuation();
        test_output_stall();
        test_random_traffic(100);

        set_idle(78, 37);
        test_random_traffic(105);

        set_idle(0, 0);
        test_random_traffic(105);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
